// ===== hw/rtl/sgf_pkg.sv =====
// Shared types and constants for the Savitzky-Golay smoothing filter.
// Used by sgf_mac and savgol_smoothing_filter; depends on nothing.
package sgf_pkg;

	// Field and storage geometry
	localparam int MAX_HALF    = 31;
	localparam int SAMPLE_BITS = 16;
	localparam int COEF_BITS   = 18;
	localparam int HALF_BITS   = 5;
	localparam int IDX_BITS    = 5;
	localparam int FRAC_BITS   = 16;

	localparam int COEF_DEPTH  = MAX_HALF + 1;
	localparam int COEF_AW     = $clog2(COEF_DEPTH);
	localparam int HIST_DEPTH  = 2 * (MAX_HALF + 1);
	localparam int HIST_AW     = $clog2(HIST_DEPTH);

	// Sample counter wraps from its top back to HIST_DEPTH
	localparam int CNT_BITS    = HIST_AW + 1;
	// Signed tap offset and signed signal position
	localparam int TAP_BITS    = HALF_BITS + 2;
	localparam int POS_BITS    = CNT_BITS + 3;

	localparam int PROD_BITS   = COEF_BITS + SAMPLE_BITS;
	localparam int ACC_BITS    = PROD_BITS + HALF_BITS + 2;

	localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
		ACC_BITS'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [ACC_BITS-1:0] SAT_MAX =
		(ACC_BITS'(1) <<< (SAMPLE_BITS - 1)) - ACC_BITS'(1);
	localparam logic signed [ACC_BITS-1:0] SAT_MIN = -SAT_MAX - ACC_BITS'(1);

	// Input beat kinds
	localparam logic ACT_COEF   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// Register map
	localparam int PADDR_BITS   = 3;
	localparam int REG_IDX_BITS = PADDR_BITS - 2;
	localparam logic [REG_IDX_BITS-1:0] REG_WINDOW_HALF = '0;
	localparam logic [HALF_BITS-1:0]    WINDOW_HALF_RST = HALF_BITS'(2);

	// Per-tap control traveling with the memory read data
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} tap_ctl_t;

endpackage

// ===== hw/rtl/sgf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module sgf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/sgf_mac.sv =====
// Multiply-accumulate datapath: one tap product per cycle, then round and saturate.
// Depends on sgf_pkg.
module sgf_mac import sgf_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tap_ctl_t                      ctl_s1,
	input  logic signed [COEF_BITS-1:0]   coef_s1,
	input  logic signed [SAMPLE_BITS-1:0] smp_s1,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] result
);

	tap_ctl_t                     ctl_s2;
	logic signed [PROD_BITS-1:0]  prod_s2;
	logic signed [ACC_BITS-1:0]   acc_q;
	logic                         done_q;
	logic signed [ACC_BITS-1:0]   rnd;
	logic signed [ACC_BITS-1:0]   quo;

	// Tap control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.valid && ctl_s2.last;
		end
	end

	// Product register, then accumulate; the first tap restarts the sum
	always_ff @(posedge clk) begin
		prod_s2 <= PROD_BITS'(coef_s1) * PROD_BITS'(smp_s1);
		if (ctl_s2.valid) begin
			if (ctl_s2.first) begin
				acc_q <= ACC_BITS'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_BITS'(prod_s2);
			end
		end
	end

	// Round half up out of Q16, then clip to the sample range
	always_comb begin
		rnd = acc_q + ROUND_HALF;
		quo = rnd >>> FRAC_BITS;
		if (quo > SAT_MAX) begin
			result = SAMPLE_BITS'(SAT_MAX);
		end else if (quo < SAT_MIN) begin
			result = SAMPLE_BITS'(SAT_MIN);
		end else begin
			result = quo[SAMPLE_BITS-1:0];
		end
	end

	assign done = done_q;

endmodule

// ===== hw/rtl/savgol_smoothing_filter.sv =====
// Savitzky-Golay smoothing filter, top level. Each output sweeps 2*half+1 taps
// (one history read per cycle), then waits for the MAC to drain and hands the
// result off; a last sample flushes up to half+1 outputs back to back.
// A coefficient beat, or a sample beat that opens no output, leaves it idle.
// Reset clears control, sets window_half to 2 and makes every coefficient read
// as zero until written; the sample history holds no reset value.
module savgol_smoothing_filter import sgf_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [IDX_BITS-1:0]           coef_index,
	input  logic signed [COEF_BITS-1:0]   coef_value,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] filtered,
	output logic                          end_of_signal,
	output logic                          too_short,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [PADDR_BITS-1:0]         paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]                  state_q;
	logic [HALF_BITS-1:0]        window_half_q;
	logic [CNT_BITS-1:0]         seen_q;
	logic [CNT_BITS-1:0]         center_q;
	logic [CNT_BITS-1:0]         final_q;
	logic [CNT_BITS-1:0]         n_q;
	logic                        end_known_q;
	logic                        short_q;
	logic signed [TAP_BITS-1:0]  tap_q;
	logic [COEF_DEPTH-1:0]       coef_vld_q;

	tap_ctl_t                    ctl_s1;
	logic                        cvld_s1;

	logic                        out_valid_q;
	logic signed [SAMPLE_BITS-1:0] filtered_q;
	logic                        eos_q;
	logic                        short_out_q;

	logic                        accept;
	logic                        coef_we;
	logic                        samp_acc;
	logic [CNT_BITS:0]           c_inc;
	logic [CNT_BITS-1:0]         c_cnt;
	logic signed [POS_BITS-1:0]  c_pos;
	logic signed [POS_BITS-1:0]  half_pos;
	logic signed [POS_BITS-1:0]  fst_pos;
	logic [CNT_BITS-1:0]         fst_cnt;

	logic signed [TAP_BITS-1:0]  half_tap;
	logic                        issue;
	logic                        tap_first;
	logic                        tap_last;
	logic signed [TAP_BITS-1:0]  tap_abs;
	logic [COEF_AW-1:0]          caddr;
	logic signed [POS_BITS-1:0]  n_pos;
	logic signed [POS_BITS-1:0]  p_raw;
	logic signed [POS_BITS-1:0]  p_lo;
	logic signed [POS_BITS-1:0]  p_hi;
	logic signed [POS_BITS-1:0]  p_fin;
	logic [HIST_AW-1:0]          haddr;

	logic [COEF_BITS-1:0]        coef_rdata;
	logic [SAMPLE_BITS-1:0]      hist_rdata;
	logic signed [COEF_BITS-1:0] coef_s1;
	logic                        mac_done;
	logic signed [SAMPLE_BITS-1:0] mac_result;
	logic                        out_free;
	logic                        cfg_wr;

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_half_q <= WINDOW_HALF_RST;
		end else if (cfg_wr && paddr[PADDR_BITS-1:2] == REG_WINDOW_HALF) begin
			window_half_q <= pwdata[HALF_BITS-1:0];
		end
	end

	assign prdata = (paddr[PADDR_BITS-1:2] == REG_WINDOW_HALF) ?
		32'(window_half_q) : '0;

	// Input handshake: one item at a time
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign coef_we  = accept && action == ACT_COEF;
	assign samp_acc = accept && action == ACT_SAMPLE;

	// New sample count and the first output center it opens
	always_comb begin
		c_inc    = {1'b0, seen_q} + (CNT_BITS + 1)'(1);
		c_cnt    = c_inc[CNT_BITS] ? CNT_BITS'(HIST_DEPTH) : c_inc[CNT_BITS-1:0];
		c_pos    = POS_BITS'(c_cnt);
		half_pos = POS_BITS'(window_half_q);
		fst_pos  = c_pos - POS_BITS'(1) - half_pos;
		fst_cnt  = (fst_pos < 0) ? '0 : fst_pos[CNT_BITS-1:0];
	end

	// Tap address generation with mirrored ends
	always_comb begin
		half_tap  = TAP_BITS'(window_half_q);
		issue     = (state_q == ST_RUN);
		tap_first = (tap_q == -half_tap);
		tap_last  = (tap_q == half_tap);
		tap_abs   = (tap_q < 0) ? -tap_q : tap_q;
		caddr     = tap_abs[COEF_AW-1:0];
		n_pos     = POS_BITS'(n_q);
		p_raw     = POS_BITS'(center_q) + POS_BITS'(tap_q);
		p_lo      = (p_raw < 0) ? (-POS_BITS'(1) - p_raw) : p_raw;
		if (end_known_q && p_lo >= n_pos) begin
			p_hi = (n_pos <<< 1) - POS_BITS'(1) - p_lo;
		end else begin
			p_hi = p_lo;
		end
		if (end_known_q && p_hi > n_pos - POS_BITS'(1)) begin
			p_fin = n_pos - POS_BITS'(1);
		end else begin
			p_fin = p_hi;
		end
		if (p_fin < 0) begin
			p_fin = '0;
		end
		haddr = p_fin[HIST_AW-1:0];
	end

	// Coefficient store; valid bits make unwritten entries read zero
	sgf_ram #(
		.WIDTH (COEF_BITS),
		.DEPTH (COEF_DEPTH)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_index[COEF_AW-1:0]),
		.wdata (coef_value),
		.re    (issue),
		.raddr (caddr),
		.rdata (coef_rdata)
	);

	// Sample history ring, indexed by position mod depth
	sgf_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (HIST_DEPTH)
	) u_hist_ram (
		.clk   (clk),
		.we    (samp_acc),
		.waddr (seen_q[HIST_AW-1:0]),
		.wdata (sample),
		.re    (issue),
		.raddr (haddr),
		.rdata (hist_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
		end else if (coef_we) begin
			coef_vld_q[coef_index[COEF_AW-1:0]] <= 1'b1;
		end
	end

	// Stage 1: control aligned with the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1  <= '0;
			cvld_s1 <= 1'b0;
		end else begin
			ctl_s1.valid <= issue;
			ctl_s1.first <= tap_first;
			ctl_s1.last  <= tap_last;
			cvld_s1      <= coef_vld_q[caddr];
		end
	end

	assign coef_s1 = cvld_s1 ? $signed(coef_rdata) : '0;

	sgf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.coef_s1(coef_s1),
		.smp_s1 ($signed(hist_rdata)),
		.done   (mac_done),
		.result (mac_result)
	);

	assign out_free = !out_valid_q || !out_stall;

	// Sequencer: start outputs on a sample, sweep taps, hand each result off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seen_q      <= '0;
			center_q    <= '0;
			final_q     <= '0;
			n_q         <= '0;
			end_known_q <= 1'b0;
			short_q     <= 1'b0;
			tap_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (samp_acc) begin
						tap_q <= -half_tap;
						n_q   <= c_cnt;
						if (last) begin
							seen_q      <= '0;
							center_q    <= fst_cnt;
							final_q     <= c_cnt - CNT_BITS'(1);
							end_known_q <= 1'b1;
							short_q     <= (fst_pos < 0);
							state_q     <= ST_RUN;
						end else begin
							seen_q      <= c_cnt;
							center_q    <= fst_cnt;
							final_q     <= fst_cnt;
							end_known_q <= 1'b0;
							short_q     <= 1'b0;
							if (fst_pos >= 0) begin
								state_q <= ST_RUN;
							end
						end
					end
				end
				ST_RUN: begin
					if (tap_last) begin
						state_q <= ST_DRAIN;
					end else begin
						tap_q <= tap_q + TAP_BITS'(1);
					end
				end
				ST_DRAIN: begin
					if (mac_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (center_q == final_q) begin
							state_q <= ST_IDLE;
						end else begin
							center_q <= center_q + CNT_BITS'(1);
							tap_q    <= -half_tap;
							state_q  <= ST_RUN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			filtered_q  <= mac_result;
			eos_q       <= end_known_q && (center_q == final_q);
			short_out_q <= short_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign filtered      = filtered_q;
	assign end_of_signal = eos_q;
	assign too_short     = short_out_q;

endmodule
